// File: design/rdp_pkg.sv
// Shared types and constants of the priority request dispatcher.
package rdp_pkg;

  // operation codes of an input word
  localparam logic [2:0] OP_SUBMIT     = 3'd0;
  localparam logic [2:0] OP_CANCEL_HDL = 3'd1;
  localparam logic [2:0] OP_CANCEL_TAG = 3'd2;
  localparam logic [2:0] OP_TICK       = 3'd3;
  localparam logic [2:0] OP_COMPLETE   = 3'd4;

  // result kinds
  localparam logic [2:0] KIND_ACCEPT   = 3'd0;
  localparam logic [2:0] KIND_REJECT   = 3'd1;
  localparam logic [2:0] KIND_CANCEL   = 3'd2;
  localparam logic [2:0] KIND_DISPATCH = 3'd3;
  localparam logic [2:0] KIND_TICK     = 3'd4;
  localparam logic [2:0] KIND_COMPLETE = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_CAP_BACKGROUND = 3'd0;
  localparam logic [2:0] CFG_CAP_LOW        = 3'd1;
  localparam logic [2:0] CFG_CAP_NORMAL     = 3'd2;
  localparam logic [2:0] CFG_CAP_HIGH       = 3'd3;
  localparam logic [2:0] CFG_CAP_CRITICAL   = 3'd4;
  localparam logic [2:0] CFG_CAP_TOTAL      = 3'd5;

  localparam int CAP_COUNT = 5;
  localparam logic [5:0] FLIGHT_CEILING = 6'd60;

  // dispatch result buffer, holds one tick's worth of dispatches
  localparam int RBUF_DEPTH = 64;
  localparam int RBUF_AW    = 6;

  // entry layouts
  localparam int QENTRY_W = 136; // handle, size, offset, tag
  localparam int SENTRY_W = 35;  // handle, priority
  localparam int RENTRY_W = 139; // handle, priority, size, offset, tag

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUBMIT,
    S_CAN_RD,
    S_CAN_CHK,
    S_SL_RD,
    S_SL_CHK,
    S_TK_CLS,
    S_TK_HEAD,
    S_TK_FREE,
    S_TK_RDBUF,
    S_TK_OUT,
    S_CP_RD,
    S_CP_CHK,
    S_RESULT
  } state_t;

endpackage

// File: design/rdp_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module rdp_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/priority_request_dispatcher.sv
// Strict-priority read request scheduler with per-class and total limits.
//
// Input channel (in_valid/in_stall) carries one word per operation: submit,
// cancel by handle, cancel by tag, tick or completion. The block works on
// one word at a time and holds in_stall high until its last result is
// loaded into the output register. Output channel (out_valid/out_stall)
// gives one or more result words; the final one of an operation has last set.
// All operations run under one sequencer over single-port reads of the stores:
//   submit appends one entry unless rejected; completion scans the slots until a
//   match or the last slot; cancel reads every queued entry of each class and,
//   by handle, then walks all slots; tick examines class heads, searches for a
//   free slot for each head it dispatches, then reads out the dispatch results.
// Results of a tick are buffered so all carry the final counts.
// Configuration port (cfg_valid/cfg_ready) is always ready; write it only
// while idle. Reset (rst, synchronous) empties all FIFOs and slots, sets caps
// to 4, the total cap to unlimited and the next handle to 1; no clearing
// pass is needed. A stalled receiver holds the output register and the
// sequencer waits in front of it.
module priority_request_dispatcher #(
  parameter int QUEUE_DEPTH     = 16,
  parameter int PRIORITY_LEVELS = 5,
  parameter int SLOT_COUNT      = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [2:0]  priority_req,
  input  logic [31:0] request_size,
  input  logic [39:0] request_offset,
  input  logic [31:0] tag,
  input  logic [31:0] handle,
  input  logic        ok,
  input  logic [31:0] bytes_read,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [31:0] out_handle,
  output logic [2:0]  out_priority,
  output logic [31:0] out_size,
  output logic [39:0] out_offset,
  output logic [31:0] out_tag,
  output logic [6:0]  cancel_count,
  output logic        deliver,
  output logic [6:0]  queued_count,
  output logic [5:0]  in_flight_count,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  localparam int QSTORE = PRIORITY_LEVELS * QUEUE_DEPTH;
  localparam int QAW = $clog2(QSTORE);
  localparam int HW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int CLW = $clog2(PRIORITY_LEVELS);
  localparam int SW  = $clog2(SLOT_COUNT);
  localparam int TW  = $clog2(QSTORE + 1);

  // configuration
  logic [3:0] caps [rdp_pkg::CAP_COUNT];
  logic [5:0] cap_total;

  // queue and slot control state
  logic [HW-1:0]       qhead [PRIORITY_LEVELS];
  logic [CW-1:0]       qcount [PRIORITY_LEVELS];
  logic [3:0]          cif [PRIORITY_LEVELS];
  logic [5:0]          tif;
  logic [TW-1:0]       qtotal;
  logic [SLOT_COUNT-1:0] slot_valid;
  logic [31:0]         next_id;
  logic [63:0]         seen_count, done_count, fail_count, done_bytes;

  // sequencer
  rdp_pkg::state_t state, state_next;
  logic [2:0]   r_op, r_pri;
  logic [31:0]  r_size, r_tag, r_handle, r_bytes;
  logic [39:0]  r_off;
  logic         r_ok;
  logic [CLW-1:0] cls;
  logic [CW-1:0]  pos;
  logic [SW-1:0]  slot;
  logic [TW-1:0]  marked;
  logic [QAW-1:0] qaddr;
  logic [rdp_pkg::RBUF_AW-1:0] nres, kres;
  logic [2:0]   res_kind;
  logic [31:0]  res_handle;
  logic         res_deliver;

  // memory ports
  logic q_we, q_re, qc_we, s_we, sc_we, rb_we, rb_re;
  logic [QAW-1:0] q_raddr, q_waddr, qc_waddr;
  logic [rdp_pkg::QENTRY_W-1:0] q_wdata, q_rdata;
  logic qc_wdata, qc_rdata, sc_wdata, sc_rdata;
  logic [rdp_pkg::SENTRY_W-1:0] s_rdata;
  logic [rdp_pkg::RENTRY_W-1:0] rb_wdata, rb_rdata;

  // output load
  logic can_load, load_out;
  logic [2:0]  ld_kind, ld_pri;
  logic [31:0] ld_handle, ld_size, ld_tag;
  logic [39:0] ld_off;
  logic [6:0]  ld_cnt;
  logic        ld_deliver, ld_last;

  // helper flags
  logic [3:0]  cur_cap;
  logic        allow, reject, qhit, smatch, slot_end, go_next;
  logic [CLW-1:0] rpri_idx, spri_idx;
  logic [2:0]  spri;
  logic [TW+6:0] marked_ext, qtotal_ext;

  // entry address of position p in class c
  function automatic logic [QAW-1:0] eidx(input logic [CLW-1:0] c,
                                          input logic [HW-1:0] hd,
                                          input logic [CW-1:0] p);
    logic [CW:0] sum;
    sum = (CW+1)'(hd) + (CW+1)'(p);
    if (32'(sum) >= QUEUE_DEPTH) begin
      sum = sum - (CW+1)'(QUEUE_DEPTH);
    end
    return QAW'(32'(c) * QUEUE_DEPTH) + QAW'(sum);
  endfunction

  rdp_ram #(.W(rdp_pkg::QENTRY_W), .D(QSTORE)) u_qdata (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .re(q_re), .raddr(q_raddr), .rdata(q_rdata));

  rdp_ram #(.W(1), .D(QSTORE)) u_qcxl (
    .clk, .we(qc_we), .waddr(qc_waddr), .wdata(qc_wdata),
    .re(q_re), .raddr(q_raddr), .rdata(qc_rdata));

  rdp_ram #(.W(rdp_pkg::SENTRY_W), .D(SLOT_COUNT)) u_sdata (
    .clk, .we(s_we), .waddr(slot), .wdata({q_rdata[135:104], 3'(cls)}),
    .re(1'b1), .raddr(slot), .rdata(s_rdata));

  rdp_ram #(.W(1), .D(SLOT_COUNT)) u_scxl (
    .clk, .we(sc_we), .waddr(slot), .wdata(sc_wdata),
    .re(1'b1), .raddr(slot), .rdata(sc_rdata));

  rdp_ram #(.W(rdp_pkg::RENTRY_W), .D(rdp_pkg::RBUF_DEPTH)) u_rbuf (
    .clk, .we(rb_we), .waddr(nres), .wdata(rb_wdata),
    .re(rb_re), .raddr(kres), .rdata(rb_rdata));

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != rdp_pkg::S_IDLE);
  assign can_load  = !out_valid || !out_stall;

  // cap of the current class; classes beyond the cap registers get none
  always_comb begin
    cur_cap = '0;
    for (int j = 0; j < rdp_pkg::CAP_COUNT; j++) begin
      if (32'(cls) == j) begin
        cur_cap = caps[j];
      end
    end
  end

  assign allow = (qcount[cls] != '0) && (cif[cls] < cur_cap) &&
                 ((cap_total == '0) || (tif < cap_total));
  assign rpri_idx = r_pri[CLW-1:0];
  assign reject = (32'(r_pri) >= PRIORITY_LEVELS) ||
                  (32'(qcount[rpri_idx]) >= QUEUE_DEPTH);
  assign qhit = ((r_op == rdp_pkg::OP_CANCEL_HDL) ? (q_rdata[135:104] == r_handle)
                                                  : (q_rdata[31:0] == r_tag)) &&
                !qc_rdata;
  assign smatch   = slot_valid[slot] && (s_rdata[34:3] == r_handle);
  assign slot_end = (32'(slot) == SLOT_COUNT - 1);
  assign spri     = s_rdata[2:0];
  assign spri_idx = spri[CLW-1:0];
  assign marked_ext = {7'd0, marked};
  assign qtotal_ext = {7'd0, qtotal};
  assign rb_wdata = {q_rdata[135:104], 3'(cls), q_rdata[103:0]};

  // next state, memory controls and output load
  always_comb begin
    state_next = state;
    q_re = 1'b0;     q_raddr = qaddr;
    q_we = 1'b0;     q_waddr = eidx(rpri_idx, qhead[rpri_idx], qcount[rpri_idx]);
    q_wdata = {next_id, r_size, r_off, r_tag};
    qc_we = 1'b0;    qc_waddr = q_waddr; qc_wdata = 1'b0;
    s_we = 1'b0;     sc_we = 1'b0; sc_wdata = 1'b0;
    rb_we = 1'b0;    rb_re = 1'b0;
    go_next = 1'b0;
    load_out = 1'b0;
    ld_kind = res_kind; ld_handle = res_handle; ld_pri = '0; ld_size = '0;
    ld_off = '0; ld_tag = '0; ld_deliver = res_deliver; ld_last = 1'b1;
    ld_cnt = (res_kind == rdp_pkg::KIND_CANCEL) ? marked_ext[6:0] : 7'd0;
    case (state)
      rdp_pkg::S_IDLE: begin
        if (in_valid) begin
          case (op)
            rdp_pkg::OP_SUBMIT:     state_next = rdp_pkg::S_SUBMIT;
            rdp_pkg::OP_CANCEL_HDL: state_next = rdp_pkg::S_CAN_RD;
            rdp_pkg::OP_CANCEL_TAG: state_next = rdp_pkg::S_CAN_RD;
            rdp_pkg::OP_TICK:       state_next = rdp_pkg::S_TK_CLS;
            rdp_pkg::OP_COMPLETE:   state_next = rdp_pkg::S_CP_RD;
            default:                state_next = rdp_pkg::S_IDLE;
          endcase
        end
      end
      rdp_pkg::S_SUBMIT: begin
        if (!reject) begin
          q_we = 1'b1;
          qc_we = 1'b1;
        end
        state_next = rdp_pkg::S_RESULT;
      end
      rdp_pkg::S_CAN_RD: begin
        if (pos < qcount[cls]) begin
          q_re = 1'b1;
          q_raddr = eidx(cls, qhead[cls], pos);
          state_next = rdp_pkg::S_CAN_CHK;
        end else if (32'(cls) == PRIORITY_LEVELS - 1) begin
          state_next = (r_op == rdp_pkg::OP_CANCEL_HDL) ? rdp_pkg::S_SL_RD
                                                        : rdp_pkg::S_RESULT;
        end
      end
      rdp_pkg::S_CAN_CHK: begin
        qc_waddr = qaddr;
        qc_wdata = 1'b1;
        qc_we = qhit;
        state_next = rdp_pkg::S_CAN_RD;
      end
      rdp_pkg::S_SL_RD: state_next = rdp_pkg::S_SL_CHK;
      rdp_pkg::S_SL_CHK: begin
        sc_wdata = 1'b1;
        sc_we = smatch;
        state_next = slot_end ? rdp_pkg::S_RESULT : rdp_pkg::S_SL_RD;
      end
      rdp_pkg::S_TK_CLS: begin
        if (allow) begin
          q_re = 1'b1;
          q_raddr = eidx(cls, qhead[cls], '0);
          state_next = rdp_pkg::S_TK_HEAD;
        end else begin
          go_next = 1'b1;
        end
      end
      rdp_pkg::S_TK_HEAD: begin
        if (qc_rdata) begin
          state_next = rdp_pkg::S_TK_CLS;
        end else if (tif >= rdp_pkg::FLIGHT_CEILING) begin
          go_next = 1'b1;
        end else begin
          state_next = rdp_pkg::S_TK_FREE;
        end
      end
      rdp_pkg::S_TK_FREE: begin
        if (!slot_valid[slot]) begin
          s_we = 1'b1;
          sc_we = 1'b1;
          rb_we = 1'b1;
          state_next = rdp_pkg::S_TK_CLS;
        end else if (slot_end) begin
          go_next = 1'b1;
        end
      end
      rdp_pkg::S_TK_RDBUF: begin
        rb_re = 1'b1;
        state_next = rdp_pkg::S_TK_OUT;
      end
      rdp_pkg::S_TK_OUT: begin
        ld_kind = rdp_pkg::KIND_DISPATCH;
        ld_handle = rb_rdata[138:107];
        ld_pri = rb_rdata[106:104];
        ld_size = rb_rdata[103:72];
        ld_off = rb_rdata[71:32];
        ld_tag = rb_rdata[31:0];
        ld_cnt = 7'd0;
        ld_deliver = 1'b0;
        ld_last = 1'b0;
        if (can_load) begin
          load_out = 1'b1;
          state_next = (kres == nres - 1'b1) ? rdp_pkg::S_RESULT : rdp_pkg::S_TK_RDBUF;
        end
      end
      rdp_pkg::S_CP_RD: state_next = rdp_pkg::S_CP_CHK;
      rdp_pkg::S_CP_CHK: begin
        if (smatch || slot_end) begin
          state_next = rdp_pkg::S_RESULT;
        end else begin
          state_next = rdp_pkg::S_CP_RD;
        end
      end
      rdp_pkg::S_RESULT: begin
        if (can_load) begin
          load_out = 1'b1;
          state_next = rdp_pkg::S_IDLE;
        end
      end
      default: state_next = rdp_pkg::S_IDLE;
    endcase
    // leaving a class: step down, or finish the tick
    if (go_next) begin
      if (cls != '0) begin
        state_next = rdp_pkg::S_TK_CLS;
      end else if (nres == '0) begin
        state_next = rdp_pkg::S_RESULT;
      end else begin
        state_next = rdp_pkg::S_TK_RDBUF;
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < rdp_pkg::CAP_COUNT; j++) caps[j] <= 4'd4;
      cap_total <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rdp_pkg::CFG_CAP_BACKGROUND: caps[0] <= cfg_data[3:0];
        rdp_pkg::CFG_CAP_LOW:        caps[1] <= cfg_data[3:0];
        rdp_pkg::CFG_CAP_NORMAL:     caps[2] <= cfg_data[3:0];
        rdp_pkg::CFG_CAP_HIGH:       caps[3] <= cfg_data[3:0];
        rdp_pkg::CFG_CAP_CRITICAL:   caps[4] <= cfg_data[3:0];
        rdp_pkg::CFG_CAP_TOTAL:      cap_total <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched input word and walk counters
  always_ff @(posedge clk) begin
    case (state)
      rdp_pkg::S_IDLE: begin
        if (in_valid) begin
          r_op <= op; r_pri <= priority_req; r_size <= request_size;
          r_off <= request_offset; r_tag <= tag; r_handle <= handle;
          r_ok <= ok; r_bytes <= bytes_read;
          cls <= (op == rdp_pkg::OP_TICK) ? CLW'(PRIORITY_LEVELS - 1) : '0;
          pos <= '0; slot <= '0; marked <= '0; nres <= '0; kres <= '0;
          res_deliver <= 1'b0;
          res_handle <= (op == rdp_pkg::OP_COMPLETE) ? handle : 32'd0;
          case (op)
            rdp_pkg::OP_TICK:     res_kind <= rdp_pkg::KIND_TICK;
            rdp_pkg::OP_COMPLETE: res_kind <= rdp_pkg::KIND_COMPLETE;
            default:              res_kind <= rdp_pkg::KIND_CANCEL;
          endcase
        end
      end
      rdp_pkg::S_SUBMIT: begin
        res_kind <= reject ? rdp_pkg::KIND_REJECT : rdp_pkg::KIND_ACCEPT;
        res_handle <= reject ? 32'd0 : next_id;
      end
      rdp_pkg::S_CAN_RD: begin
        if (pos < qcount[cls]) begin
          qaddr <= q_raddr;
        end else if (32'(cls) != PRIORITY_LEVELS - 1) begin
          cls <= cls + 1'b1;
          pos <= '0;
        end
      end
      rdp_pkg::S_CAN_CHK: begin
        if (qhit) marked <= marked + 1'b1;
        pos <= pos + 1'b1;
      end
      rdp_pkg::S_SL_CHK: if (!slot_end) slot <= slot + 1'b1;
      rdp_pkg::S_TK_HEAD: slot <= '0;
      rdp_pkg::S_TK_FREE: begin
        if (!slot_valid[slot]) begin
          nres <= nres + 1'b1;
        end else if (!slot_end) begin
          slot <= slot + 1'b1;
        end
      end
      rdp_pkg::S_TK_OUT: if (can_load) kres <= kres + 1'b1;
      rdp_pkg::S_CP_CHK: begin
        if (smatch) begin
          res_deliver <= !sc_rdata;
        end else if (!slot_end) begin
          slot <= slot + 1'b1;
        end
      end
      default: ;
    endcase
    if (go_next && cls != '0) cls <= cls - 1'b1;
  end

  // queue, slot and flight bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < PRIORITY_LEVELS; c++) begin
        qhead[c] <= '0; qcount[c] <= '0; cif[c] <= '0;
      end
      tif <= '0; qtotal <= '0; slot_valid <= '0; next_id <= 32'd1;
      seen_count <= '0; done_count <= '0; fail_count <= '0; done_bytes <= '0;
    end else begin
      case (state)
        rdp_pkg::S_SUBMIT: begin
          if (!reject) begin
            qcount[rpri_idx] <= qcount[rpri_idx] + 1'b1;
            qtotal <= qtotal + 1'b1;
            next_id <= next_id + 32'd1;
            seen_count <= seen_count + 64'd1;
          end
        end
        rdp_pkg::S_TK_HEAD, rdp_pkg::S_TK_FREE: begin
          // drop a marked head, or pop the head just dispatched
          if ((state == rdp_pkg::S_TK_HEAD && qc_rdata) ||
              (state == rdp_pkg::S_TK_FREE && !slot_valid[slot])) begin
            qhead[cls] <= (32'(qhead[cls]) == QUEUE_DEPTH - 1) ? '0 : qhead[cls] + 1'b1;
            qcount[cls] <= qcount[cls] - 1'b1;
            qtotal <= qtotal - 1'b1;
          end
          if (state == rdp_pkg::S_TK_FREE && !slot_valid[slot]) begin
            slot_valid[slot] <= 1'b1;
            cif[cls] <= cif[cls] + 4'd1;
            tif <= tif + 6'd1;
          end
        end
        rdp_pkg::S_CP_CHK: begin
          if (smatch) begin
            slot_valid[slot] <= 1'b0;
            if (32'(spri) < PRIORITY_LEVELS && cif[spri_idx] != '0) begin
              cif[spri_idx] <= cif[spri_idx] - 4'd1;
            end
            if (tif != '0) tif <= tif - 6'd1;
            if (!sc_rdata) begin
              if (r_ok) begin
                done_count <= done_count + 64'd1;
                done_bytes <= done_bytes + {32'd0, r_bytes};
              end else begin
                fail_count <= fail_count + 64'd1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      kind <= ld_kind; out_handle <= ld_handle; out_priority <= ld_pri;
      out_size <= ld_size; out_offset <= ld_off; out_tag <= ld_tag;
      cancel_count <= ld_cnt; deliver <= ld_deliver; last <= ld_last;
      queued_count <= qtotal_ext[6:0];
      in_flight_count <= tif;
    end
  end

endmodule
